// ===== sv/lsot_pkg.sv =====
package lsot_pkg;

  // field widths
  localparam int JD_W    = 54;
  localparam int OFS_W   = 40;
  localparam int MJD_W   = 49;
  localparam int DRIFT_W = 41;
  localparam int CMD_W   = 2;

  localparam int TABLE_DEPTH_DEF = 64;

  // 2400000.5 days in unsigned Q32
  localparam logic [JD_W-1:0] JD_OFFSET_Q32 = 54'h249F0080000000;

  // difference of two dates is one bit wider and signed
  localparam int DIFF_W   = MJD_W + 1;
  // magnitudes fed to the multiplier
  localparam int MAG_A_W  = MJD_W;
  localparam int MAG_B_W  = DRIFT_W;
  localparam int MUL_DIG  = 8;
  localparam int MUL_STEPS = (MAG_B_W + MUL_DIG - 1) / MUL_DIG;
  localparam int MUL_BPAD = MUL_DIG * MUL_STEPS;
  localparam int PROD_W   = MAG_A_W + MAG_B_W;
  localparam int SPROD_W  = PROD_W + 1;
  localparam int FRAC_DROP = 40;
  localparam int Q_W      = SPROD_W - FRAC_DROP;
  localparam int SUM_W    = Q_W + 1;

  localparam logic [SPROD_W-1:0] ROUND_HALF = SPROD_W'(1) << (FRAC_DROP - 1);

  localparam logic signed [OFS_W-1:0] LSEC_MAX = {1'b0, {(OFS_W-1){1'b1}}};
  localparam logic signed [OFS_W-1:0] LSEC_MIN = {1'b1, {(OFS_W-1){1'b0}}};

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_READY  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ABS,
    ST_MUL,
    ST_NEG,
    ST_RND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [JD_W-1:0]           start_jd;
    logic signed [OFS_W-1:0]   base_ofs;
    logic [MJD_W-1:0]          ref_mjd;
    logic signed [DRIFT_W-1:0] drift;
  } seg_t;

endpackage

// ===== sv/lsot_if.sv =====
interface lsot_in_if import lsot_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [JD_W-1:0]           entry_julian_date;
  logic signed [OFS_W-1:0]   entry_base_offset;
  logic [MJD_W-1:0]          entry_reference_mjd;
  logic signed [DRIFT_W-1:0] entry_drift_rate;
  logic [MJD_W-1:0]          query_mjd;

  modport source (
    output valid, command, entry_julian_date, entry_base_offset,
           entry_reference_mjd, entry_drift_rate, query_mjd,
    input  ready
  );
  modport sink (
    input  valid, command, entry_julian_date, entry_base_offset,
           entry_reference_mjd, entry_drift_rate, query_mjd,
    output ready
  );
endinterface

interface lsot_out_if import lsot_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OFS_W-1:0] leap_seconds;
  logic                    entry_found;
  logic                    status;

  modport source (
    output valid, leap_seconds, entry_found, status,
    input  ready
  );
  modport sink (
    input  valid, leap_seconds, entry_found, status,
    output ready
  );
endinterface

// ===== sv/lsot_ram.sv =====
module lsot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lsot_mul.sv =====
module lsot_mul import lsot_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MAG_A_W-1:0] a_mag,
  input  logic [MAG_B_W-1:0] b_mag,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  localparam int CNT_W = $clog2(MUL_STEPS + 1);

  logic [MAG_A_W-1:0]         a_r, a_nxt;
  logic [MUL_BPAD-1:0]        b_r, b_nxt;
  logic [PROD_W-1:0]          acc_r, acc_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [MAG_A_W+MUL_DIG-1:0] pp;

  // MSB digit first: acc = acc * 2^8 + a * digit
  assign pp = a_r * b_r[MUL_BPAD-1 -: MUL_DIG];

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a_mag;
      b_nxt    = {{(MUL_BPAD-MAG_B_W){1'b0}}, b_mag};
      acc_nxt  = '0;
      cnt_nxt  = CNT_W'(MUL_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r << MUL_DIG) + PROD_W'(pp);
      b_nxt   = b_r << MUL_DIG;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== sv/leap_second_offset_table.sv =====
// Channel  Dir  Payload
// in_ch    in   command, entry_julian_date, entry_base_offset, entry_reference_mjd,
//               entry_drift_rate, query_mjd
// out_ch   out  leap_seconds, entry_found, status (one word per input word)
//
// Append, mark-ready, unused commands and queries that skip the scan go straight
// to the output state. A query with a match reads entries newest first up to the
// match; without a match it reads every filled entry, then goes to the output state.
// The table RAM has a registered read port and yields one entry per cycle,
// then a 49x8 multiplier makes six passes for the drift product.
// One word in flight; a finished word may wait in the output register while the
// next word is taken. Synchronous active-low reset empties the table and clears its ready flag.
module leap_second_offset_table import lsot_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lsot_in_if.sink     in_ch,
  lsot_out_if.source  out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      tbl_rdy_r, tbl_rdy_nxt;
  logic [CW-1:0]             remain_r, remain_nxt;
  logic                      pend_r, pend_nxt;
  logic [JD_W-1:0]           jd_r, jd_nxt;
  logic [MJD_W-1:0]          mjd_r, mjd_nxt;
  logic signed [DIFF_W-1:0]  diff_r, diff_nxt;
  logic signed [DRIFT_W-1:0] drift_r, drift_nxt;
  logic signed [OFS_W-1:0]   base_r, base_nxt;
  logic                      neg_r, neg_nxt;
  logic [SPROD_W-1:0]        prod_r, prod_nxt;
  logic [Q_W-1:0]            q_r, q_nxt;
  logic signed [OFS_W-1:0]   res_r, res_nxt;
  logic                      found_r, found_nxt;
  logic                      stat_r, stat_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [OFS_W-1:0]   out_lsec_r, out_lsec_nxt;
  logic                      out_found_r, out_found_nxt;
  logic                      out_stat_r, out_stat_nxt;

  logic                      in_acc;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  seg_t                      ram_wdata, seg_rd;
  logic [$bits(seg_t)-1:0]   ram_rdata;
  logic [CW-1:0]             rem_m1;
  logic                      issue, jd_hit;
  logic [DIFF_W-1:0]         diff_sub, diff_neg;
  logic [DRIFT_W-1:0]        drift_neg;
  logic                      mul_start, mul_done;
  logic [MAG_A_W-1:0]        a_mag;
  logic [MAG_B_W-1:0]        b_mag;
  logic [PROD_W-1:0]         mul_prod;
  logic [SPROD_W-1:0]        rnd_sum;
  logic [SUM_W-1:0]          sum;
  logic                      sum_fits;

  lsot_ram #(
    .WIDTH ($bits(seg_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsot_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_mag (a_mag),
    .b_mag (b_mag),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = '{start_jd: in_ch.entry_julian_date,
                       base_ofs: in_ch.entry_base_offset,
                       ref_mjd:  in_ch.entry_reference_mjd,
                       drift:    in_ch.entry_drift_rate};
  assign seg_rd    = seg_t'(ram_rdata);

  // scan walks from the newest entry down
  assign issue     = (remain_r != '0);
  assign rem_m1    = remain_r - 1'b1;
  assign ram_raddr = rem_m1[AW-1:0];
  assign jd_hit    = jd_r > seg_rd.start_jd;
  assign diff_sub  = {1'b0, mjd_r} - {1'b0, seg_rd.ref_mjd};

  assign diff_neg  = -diff_r;
  assign drift_neg = -drift_r;
  assign a_mag     = diff_r[DIFF_W-1] ? diff_neg[MAG_A_W-1:0] : diff_r[MAG_A_W-1:0];
  assign b_mag     = drift_r[DRIFT_W-1] ? drift_neg : drift_r;

  // round half up from Q72 to Q32
  assign rnd_sum  = prod_r + ROUND_HALF;
  assign sum      = {q_r[Q_W-1], q_r} + {{(SUM_W-OFS_W){base_r[OFS_W-1]}}, base_r};
  assign sum_fits = (&sum[SUM_W-1:OFS_W-1]) || !(|sum[SUM_W-1:OFS_W-1]);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tbl_rdy_nxt   = tbl_rdy_r;
    remain_nxt    = remain_r;
    pend_nxt      = pend_r;
    jd_nxt        = jd_r;
    mjd_nxt       = mjd_r;
    diff_nxt      = diff_r;
    drift_nxt     = drift_r;
    base_nxt      = base_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    q_nxt         = q_r;
    res_nxt       = res_r;
    found_nxt     = found_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_lsec_nxt  = out_lsec_r;
    out_found_nxt = out_found_r;
    out_stat_nxt  = out_stat_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    mul_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt   = '0;
          found_nxt = 1'b0;
          stat_nxt  = STATUS_OK;
          jd_nxt    = {{(JD_W-MJD_W){1'b0}}, in_ch.query_mjd} + JD_OFFSET_Q32;
          mjd_nxt   = in_ch.query_mjd;
          state_nxt = ST_OUT;
          case (cmd_t'(in_ch.command))
            CMD_APPEND: begin
              if (count_r == CW'(TABLE_DEPTH)) begin
                stat_nxt = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_QUERY: begin
              if (tbl_rdy_r && (count_r != '0)) begin
                remain_nxt = count_r;
                pend_nxt   = 1'b0;
                state_nxt  = ST_SCAN;
              end
            end
            CMD_READY: begin
              tbl_rdy_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        ram_re   = issue;
        pend_nxt = issue;
        if (issue) begin
          remain_nxt = rem_m1;
        end
        if (pend_r && jd_hit) begin
          diff_nxt  = diff_sub;
          drift_nxt = seg_rd.drift;
          base_nxt  = seg_rd.base_ofs;
          state_nxt = ST_ABS;
        end else if (!issue) begin
          state_nxt = ST_OUT;
        end
      end

      ST_ABS: begin
        neg_nxt   = diff_r[DIFF_W-1] ^ drift_r[DRIFT_W-1];
        mul_start = 1'b1;
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_NEG;
        end
      end

      ST_NEG: begin
        prod_nxt  = neg_r ? -{1'b0, mul_prod} : {1'b0, mul_prod};
        state_nxt = ST_RND;
      end

      ST_RND: begin
        q_nxt     = rnd_sum[SPROD_W-1:FRAC_DROP];
        state_nxt = ST_ADD;
      end

      ST_ADD: begin
        if (sum_fits) begin
          res_nxt = sum[OFS_W-1:0];
        end else begin
          res_nxt = sum[SUM_W-1] ? LSEC_MIN : LSEC_MAX;
        end
        found_nxt = 1'b1;
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_lsec_nxt  = res_r;
          out_found_nxt = found_r;
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      tbl_rdy_r   <= 1'b0;
      remain_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tbl_rdy_r   <= tbl_rdy_nxt;
      remain_r    <= remain_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    jd_r        <= jd_nxt;
    mjd_r       <= mjd_nxt;
    diff_r      <= diff_nxt;
    drift_r     <= drift_nxt;
    base_r      <= base_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    q_r         <= q_nxt;
    res_r       <= res_nxt;
    found_r     <= found_nxt;
    stat_r      <= stat_nxt;
    out_lsec_r  <= out_lsec_nxt;
    out_found_r <= out_found_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.leap_seconds = out_lsec_r;
  assign out_ch.entry_found  = out_found_r;
  assign out_ch.status       = out_stat_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_scan_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (tbl_rdy_r && (count_r != '0)))
    else $error("scan started on unready or empty table");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("multiplier finished outside multiply state");

  a_full_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r == STATUS_FULL)) |-> (!out_found_r && (out_lsec_r == '0)))
    else $error("dropped append word carries a lookup result");

endmodule
